[src/rcfir_pkg.sv]
// Shared types and constants for the response convolution FIR block.
// Used by every module in src but rcfir_ram; depends on nothing.
package rcfir_pkg;

  // Width of a stored sample and of a coefficient.
  localparam int SAMPLE_BITS = 16;
  localparam int COEF_BITS   = 16;
  localparam int PROD_W      = SAMPLE_BITS + COEF_BITS;
  localparam int OUT_W       = 32;

  // Item commands.
  localparam logic CMD_LOAD   = 1'b0;
  localparam logic CMD_SAMPLE = 1'b1;

  // Configuration register indexes.
  localparam logic REG_TAPS_IN_USE  = 1'b0;
  localparam logic REG_RESULT_SHIFT = 1'b1;

  // Register reset values.
  localparam logic [6:0] TAPS_RESET  = 7'd64;
  localparam logic [4:0] SHIFT_RESET = 5'd15;

  typedef struct packed {
    logic              cmd;
    logic [5:0]        tap_index;
    logic signed [15:0] coef_value;
    logic signed [15:0] sample_value;
    logic              first_of_trace;
  } item_t;

  typedef struct packed {
    logic signed [31:0] filtered_value;
    logic               saturated;
  } result_t;

  // Per-tap control that travels alongside the memory reads.
  typedef struct packed {
    logic issue;
    logic live;
    logic first;
    logic last;
  } mac_ctl_t;

endpackage

[src/rcfir_ram.sv]
// Simple dual-port memory: one write port, one read port, registered read data.
// Depends on nothing.
module rcfir_ram #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

[src/rcfir_mac.sv]
// Multiply-accumulate pipeline: aligns tap control with the memory read data,
// registers the product and sums it. Depends on rcfir_pkg.
module rcfir_mac #(
  parameter int ACC_W = 40
) (
  input  logic                                    clk,
  input  logic                                    rst,
  input  rcfir_pkg::mac_ctl_t                     ctl,
  input  logic signed [rcfir_pkg::COEF_BITS-1:0]   coef,
  input  logic signed [rcfir_pkg::SAMPLE_BITS-1:0] sample,
  output logic signed [ACC_W-1:0]                 acc,
  output logic                                    acc_done
);

  rcfir_pkg::mac_ctl_t ctl_rd;
  rcfir_pkg::mac_ctl_t ctl_prod;
  logic signed [rcfir_pkg::PROD_W-1:0] prod;
  logic signed [ACC_W-1:0] prod_ext;

  // ctl_rd lines up with the registered read data of both memories.
  always_ff @(posedge clk) begin
    if (rst) begin
      ctl_rd   <= '0;
      ctl_prod <= '0;
      acc_done <= 1'b0;
    end else begin
      ctl_rd   <= ctl;
      ctl_prod <= ctl_rd;
      acc_done <= ctl_prod.issue && ctl_prod.last;
    end
  end

  // A tap beyond the samples seen since the trace began contributes zero.
  always_ff @(posedge clk) begin
    if (ctl_rd.live) begin
      prod <= coef * sample;
    end else begin
      prod <= '0;
    end
  end

  assign prod_ext = {{(ACC_W - rcfir_pkg::PROD_W){prod[rcfir_pkg::PROD_W-1]}}, prod};

  always_ff @(posedge clk) begin
    if (ctl_prod.issue) begin
      if (ctl_prod.first) begin
        acc <= prod_ext;
      end else begin
        acc <= acc + prod_ext;
      end
    end
  end

endmodule

[src/rcfir_post.sv]
// Output scaling: arithmetic right shift of the sum, then saturation to 32 bits.
// Two register stages. Depends on rcfir_pkg.
module rcfir_post #(
  parameter int ACC_W = 40
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    acc_done,
  input  logic signed [ACC_W-1:0] acc,
  input  logic [4:0]              result_shift,
  output rcfir_pkg::result_t      res,
  output logic                    res_done
);

  logic                    shifted_vld;
  logic signed [ACC_W-1:0] shifted;
  logic                    overflow;
  logic                    all_ones;
  logic                    all_zeros;

  always_ff @(posedge clk) begin
    if (rst) begin
      shifted_vld <= 1'b0;
      res_done    <= 1'b0;
    end else begin
      shifted_vld <= acc_done;
      res_done    <= shifted_vld;
    end
  end

  // Arithmetic shift rounds towards minus infinity.
  always_ff @(posedge clk) begin
    if (acc_done) begin
      shifted <= acc >>> result_shift;
    end
  end

  // The value fits when every bit from bit 31 upwards equals the sign.
  assign all_ones  = &shifted[ACC_W-1:rcfir_pkg::OUT_W-1];
  assign all_zeros = ~|shifted[ACC_W-1:rcfir_pkg::OUT_W-1];
  assign overflow  = !(all_ones || all_zeros);

  always_ff @(posedge clk) begin
    if (shifted_vld) begin
      res.saturated <= overflow;
      if (!overflow) begin
        res.filtered_value <= shifted[rcfir_pkg::OUT_W-1:0];
      end else if (shifted[ACC_W-1]) begin
        res.filtered_value <= {1'b1, {(rcfir_pkg::OUT_W-1){1'b0}}};
      end else begin
        res.filtered_value <= {1'b0, {(rcfir_pkg::OUT_W-1){1'b1}}};
      end
    end
  end

endmodule

[src/response_convolution_fir.sv]
// Response convolution FIR: top level. Depends on rcfir_pkg, rcfir_ram,
// rcfir_mac and rcfir_post.
//
// This block convolves a stream of signed current samples with an electronic
// response held in an on-chip coefficient memory, one filtered result per
// sample item. A load item (cmd low) writes one Q1.15 coefficient at tap_index
// and gives no result; a load with tap_index of MAX_TAPS or more is dropped.
// A sample item writes its sample into a circular history memory and then
// walks the taps one per cycle through a single shared multiplier, reading one
// coefficient and one delayed sample each cycle. From its acceptance, a
// sample item goes through these steps in order: the acceptance itself, the
// memory reads, one per tap, then the multiply, accumulate, shift and
// saturate stages, the control seeing the finished result, and the hand-over
// of the item to the output register. The input is stalled from the
// acceptance until that hand-over, so the block takes no new item before it
// is through with the last sample item. A sample with first_of_trace set
// starts a new trace: a fill count records how many samples the current
// trace holds, and older history entries read as zero without any clearing
// pass. The sum is shifted right by result_shift (rounding towards minus
// infinity) and saturated to 32 bits, with saturated set when clipping took
// place. A finished result sits in the output register until taken, while
// the input side is already free for the next item. Coefficients that were
// never written read back as undefined. Configuration (index 0: taps_in_use,
// taken as 1 when zero and capped at MAX_TAPS; index 1: result_shift) is to
// be written by the user only while the block is idle, which the block
// itself has no check for; cfg_ready is always high.
module response_convolution_fir #(
  parameter int MAX_TAPS = 64
) (
  input  logic               clk,
  input  logic               rst,
  // Item input channel
  input  logic               item_valid,
  output logic               item_stall,
  input  rcfir_pkg::item_t   item,
  // Result output channel
  output logic               result_valid,
  input  logic               result_stall,
  output rcfir_pkg::result_t result,
  // Configuration write channel
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic               cfg_index,
  input  logic [6:0]         cfg_data
);

  localparam int AW    = $clog2(MAX_TAPS);
  localparam int CNT_W = $clog2(MAX_TAPS + 1);
  localparam int ACC_W = rcfir_pkg::PROD_W + $clog2(MAX_TAPS) + 1;

  localparam logic [1:0] ST_IDLE    = 2'd0;
  localparam logic [1:0] ST_RUN     = 2'd1;
  localparam logic [1:0] ST_WAIT    = 2'd2;
  localparam logic [1:0] ST_DELIVER = 2'd3;

  logic [1:0]       state;
  logic [1:0]       state_next;
  logic [6:0]       taps_in_use;
  logic [4:0]       result_shift;
  logic [AW-1:0]    hist_ptr;
  logic [AW-1:0]    hist_ptr_next;
  logic [CNT_W-1:0] fill;
  logic [CNT_W-1:0] fill_next;
  logic [AW-1:0]    rd_ptr;
  logic [AW-1:0]    rd_ptr_next;
  logic [CNT_W-1:0] tap_cnt;
  logic [CNT_W-1:0] tap_cnt_next;
  logic [CNT_W-1:0] taps_run;
  logic [CNT_W-1:0] taps_run_next;
  logic [CNT_W-1:0] taps_eff;

  logic             item_accept;
  logic             load_accept;
  logic             sample_accept;
  logic [AW-1:0]    pos_now;

  rcfir_pkg::mac_ctl_t ctl;
  logic signed [rcfir_pkg::COEF_BITS-1:0]   coef_rd;
  logic signed [rcfir_pkg::SAMPLE_BITS-1:0] sample_rd;
  logic signed [ACC_W-1:0]                  acc;
  logic                                     acc_done;
  rcfir_pkg::result_t                       post_res;
  logic                                     post_done;
  logic                                     out_free;

  assign item_stall    = (state != ST_IDLE);
  assign item_accept   = item_valid && !item_stall;
  assign load_accept   = item_accept && (item.cmd == rcfir_pkg::CMD_LOAD)
                         && (32'(item.tap_index) < MAX_TAPS);
  assign sample_accept = item_accept && (item.cmd == rcfir_pkg::CMD_SAMPLE);
  assign cfg_ready     = 1'b1;
  assign out_free      = !result_valid || !result_stall;

  // Effective tap count: zero means one, anything above the store is capped.
  always_comb begin
    if (taps_in_use == 7'd0) begin
      taps_eff = CNT_W'(1);
    end else if (32'(taps_in_use) > MAX_TAPS) begin
      taps_eff = CNT_W'(MAX_TAPS);
    end else begin
      taps_eff = CNT_W'(taps_in_use);
    end
  end

  // A new trace restarts the history at entry zero.
  assign pos_now = item.first_of_trace ? '0 : hist_ptr;

  // Tap control issued alongside the memory read addresses.
  always_comb begin
    ctl       = '0;
    ctl.issue = (state == ST_RUN);
    ctl.live  = (tap_cnt < fill);
    ctl.first = (tap_cnt == '0);
    ctl.last  = (tap_cnt == taps_run - CNT_W'(1));
  end

  always_comb begin
    state_next    = state;
    hist_ptr_next = hist_ptr;
    fill_next     = fill;
    rd_ptr_next   = rd_ptr;
    tap_cnt_next  = tap_cnt;
    taps_run_next = taps_run;
    case (state)
      ST_IDLE: begin
        if (sample_accept) begin
          if (pos_now == AW'(MAX_TAPS - 1)) begin
            hist_ptr_next = '0;
          end else begin
            hist_ptr_next = pos_now + AW'(1);
          end
          if (item.first_of_trace) begin
            fill_next = CNT_W'(1);
          end else if (fill != CNT_W'(MAX_TAPS)) begin
            fill_next = fill + CNT_W'(1);
          end
          rd_ptr_next   = pos_now;
          tap_cnt_next  = '0;
          taps_run_next = taps_eff;
          state_next    = ST_RUN;
        end
      end
      ST_RUN: begin
        tap_cnt_next = tap_cnt + CNT_W'(1);
        if (rd_ptr == '0) begin
          rd_ptr_next = AW'(MAX_TAPS - 1);
        end else begin
          rd_ptr_next = rd_ptr - AW'(1);
        end
        if (ctl.last) begin
          state_next = ST_WAIT;
        end
      end
      ST_WAIT: begin
        if (post_done) begin
          state_next = ST_DELIVER;
        end
      end
      ST_DELIVER: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      hist_ptr <= '0;
      fill     <= '0;
    end else begin
      state    <= state_next;
      hist_ptr <= hist_ptr_next;
      fill     <= fill_next;
    end
  end

  always_ff @(posedge clk) begin
    rd_ptr   <= rd_ptr_next;
    tap_cnt  <= tap_cnt_next;
    taps_run <= taps_run_next;
  end

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      taps_in_use  <= rcfir_pkg::TAPS_RESET;
      result_shift <= rcfir_pkg::SHIFT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        rcfir_pkg::REG_TAPS_IN_USE:  taps_in_use  <= cfg_data;
        rcfir_pkg::REG_RESULT_SHIFT: result_shift <= cfg_data[4:0];
        default: begin
        end
      endcase
    end
  end

  // Output register: holds the finished item until the consumer takes it.
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (state == ST_DELIVER && out_free) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_DELIVER && out_free) begin
      result <= post_res;
    end
  end

  rcfir_ram #(
    .DEPTH (MAX_TAPS),
    .WIDTH (rcfir_pkg::COEF_BITS)
  ) u_coef_ram (
    .clk     (clk),
    .wr_en   (load_accept),
    .wr_addr (AW'(item.tap_index)),
    .wr_data (item.coef_value),
    .rd_addr (tap_cnt[AW-1:0]),
    .rd_data (coef_rd)
  );

  rcfir_ram #(
    .DEPTH (MAX_TAPS),
    .WIDTH (rcfir_pkg::SAMPLE_BITS)
  ) u_hist_ram (
    .clk     (clk),
    .wr_en   (sample_accept),
    .wr_addr (pos_now),
    .wr_data (item.sample_value[rcfir_pkg::SAMPLE_BITS-1:0]),
    .rd_addr (rd_ptr),
    .rd_data (sample_rd)
  );

  rcfir_mac #(
    .ACC_W (ACC_W)
  ) u_mac (
    .clk      (clk),
    .rst      (rst),
    .ctl      (ctl),
    .coef     (coef_rd),
    .sample   (sample_rd),
    .acc      (acc),
    .acc_done (acc_done)
  );

  rcfir_post #(
    .ACC_W (ACC_W)
  ) u_post (
    .clk          (clk),
    .rst          (rst),
    .acc_done     (acc_done),
    .acc          (acc),
    .result_shift (result_shift),
    .res          (post_res),
    .res_done     (post_done)
  );

endmodule

[test/response_convolution_fir_test.sv]
// Self-checking testbench for the response convolution FIR block.
// Depends on rcfir_pkg and response_convolution_fir; predicts every result
// from its own copy of the coefficient store, sample history and registers.
module response_convolution_fir_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NUM_TAPS         = 64;
  localparam int ITEM_W           = $bits(rcfir_pkg::item_t);
  // Settling time after the last result, meant to cover anything still in
  // flight from a sample item run over the full 64 taps.
  localparam int SETTLE_CYCLES    = 80;
  localparam int RANDOM_PHASES    = 12;
  localparam int ITEMS_PER_PHASE  = 84;
  // The slowest legal run is roughly 1100 items at the full tap count;
  // the limit sits several times above that.
  localparam int CYCLE_LIMIT      = 1000000;

  logic               clk;
  logic               rst          = 1'b1;
  logic               item_valid   = 1'b0;
  logic               item_stall;
  rcfir_pkg::item_t   item         = '0;
  logic               result_valid;
  logic               result_stall = 1'b0;
  rcfir_pkg::result_t result;
  logic               cfg_valid    = 1'b0;
  logic               cfg_ready;
  logic               cfg_index    = rcfir_pkg::REG_TAPS_IN_USE;
  logic [6:0]         cfg_data     = '0;

  response_convolution_fir dut (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .item         (item),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  // Predictor state: the coefficient store, the circular sample history with
  // its write position, and the two configuration registers.
  logic signed [15:0] resp_coef  [NUM_TAPS];
  logic signed [15:0] trace_hist [NUM_TAPS];
  logic [5:0]         hist_ptr   = '0;
  logic [6:0]         taps_reg   = rcfir_pkg::TAPS_RESET;
  logic [4:0]         shift_reg  = rcfir_pkg::SHIFT_RESET;

  // Filtered samples still owed by the block, oldest first.
  rcfir_pkg::result_t pending_results[$];
  rcfir_pkg::result_t oldest;

  // Idling percentages of the current phase.
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;

  // Samples left before the random stream starts a new trace.
  int trace_left = 0;

  int cycle_count     = 0;
  int mismatches      = 0;
  int items_sent      = 0;
  int samples_sent    = 0;
  int loads_sent      = 0;
  int results_checked = 0;
  int clipped_seen    = 0;
  int cfg_writes      = 0;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Timeout guard: a hung handshake ends the run here.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("%t: timeout after %0d cycles, %0d results still owed", $time,
               cycle_count, pending_results.size());
      $display("*** FAILED ***");
      $finish;
    end
  end

  // The clipped and shifted convolution of the current trace with the
  // response, for one sample item. Updates the history as the block does.
  function automatic rcfir_pkg::result_t convolve_sample(rcfir_pkg::item_t it);
    longint  acc;
    longint  shifted;
    int      taps;
    logic [5:0] pos;
    rcfir_pkg::result_t r;
    acc = 0;
    if (it.first_of_trace) begin
      // A new trace: everything older reads as zero.
      foreach (trace_hist[i]) trace_hist[i] = '0;
      hist_ptr = '0;
    end
    pos = hist_ptr;
    trace_hist[pos] = it.sample_value;
    taps = taps_reg;
    if (taps == 0) taps = 1;
    if (taps > NUM_TAPS) taps = NUM_TAPS;
    for (int j = 0; j < taps; j++)
      acc += longint'(resp_coef[j]) * longint'(trace_hist[6'(pos - j)]);
    hist_ptr = pos + 6'd1;
    // Arithmetic shift of a signed value rounds towards minus infinity.
    shifted = acc >>> shift_reg;
    r.saturated = 1'b1;
    if (shifted > 64'sd2147483647)
      r.filtered_value = 32'sh7fffffff;
    else if (shifted < -64'sd2147483648)
      r.filtered_value = 32'sh80000000;
    else begin
      r.filtered_value = shifted[31:0];
      r.saturated = 1'b0;
    end
    return r;
  endfunction

  // Applies one accepted item to the predictor.
  function automatic void absorb_item(rcfir_pkg::item_t it);
    items_sent++;
    if (it.cmd == rcfir_pkg::CMD_LOAD) begin
      resp_coef[it.tap_index] = it.coef_value;
      loads_sent++;
    end else begin
      pending_results.push_back(convolve_sample(it));
      samples_sent++;
    end
  endfunction

  // Result side: checks every accepted result against the oldest prediction,
  // then decides the stall for the next edge. The check sees the stall value
  // that the block saw at this edge, as the new one is applied afterwards.
  always @(posedge clk) begin
    if (!rst && result_valid && !result_stall) begin
      if (pending_results.size() == 0) begin
        $display("%t: result with none owed: filtered_value %0d saturated %0b",
                 $time, result.filtered_value, result.saturated);
        mismatches++;
      end else begin
        oldest = pending_results.pop_front();
        results_checked++;
        if (result.saturated === 1'b1) clipped_seen++;
        if (result.filtered_value !== oldest.filtered_value) begin
          $display("%t: filtered_value expected %0d actual %0d", $time,
                   oldest.filtered_value, result.filtered_value);
          mismatches++;
        end
        if (result.saturated !== oldest.saturated) begin
          $display("%t: saturated expected %0b actual %0b", $time,
                   oldest.saturated, result.saturated);
          mismatches++;
        end
      end
    end
    result_stall <= (recv_stall_pct != 0) && ($urandom_range(99) < recv_stall_pct);
  end

  // Offers one item and waits until the block takes it. Valid is only lowered
  // when a gap is wanted, so back-to-back items keep it high.
  task automatic send_item(rcfir_pkg::item_t it);
    if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      item_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    item_valid <= 1'b1;
    item       <= it;
    @(posedge clk);
    while (item_stall) @(posedge clk);
    absorb_item(it);
  endtask

  // Withdraws the input and waits until every owed result has come, then for
  // the given number of extra cycles.
  task automatic hold_until_drained(int extra);
    item_valid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (extra) @(posedge clk);
  endtask

  // Writes both registers; only called once the block is idle. The upper
  // data bits of a shift write are junk that the block must drop.
  task automatic set_registers(logic [6:0] taps, logic [4:0] shift);
    hold_until_drained(SETTLE_CYCLES);
    cfg_valid <= 1'b1;
    cfg_index <= rcfir_pkg::REG_TAPS_IN_USE;
    cfg_data  <= taps;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_index <= rcfir_pkg::REG_RESULT_SHIFT;
    cfg_data  <= {2'($urandom), shift};
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    @(posedge clk);
    taps_reg   = taps;
    shift_reg  = shift;
    cfg_writes += 2;
  endtask

  // Load and sample items, with random junk in the fields they ignore.
  task automatic load_coef(logic [5:0] tap, logic signed [15:0] value);
    rcfir_pkg::item_t it;
    it                = rcfir_pkg::item_t'(ITEM_W'({$urandom, $urandom}));
    it.cmd            = rcfir_pkg::CMD_LOAD;
    it.tap_index      = tap;
    it.coef_value     = value;
    send_item(it);
  endtask

  task automatic send_sample(logic signed [15:0] value, logic first);
    rcfir_pkg::item_t it;
    it                = rcfir_pkg::item_t'(ITEM_W'({$urandom, $urandom}));
    it.cmd            = rcfir_pkg::CMD_SAMPLE;
    it.sample_value   = value;
    it.first_of_trace = first;
    send_item(it);
  endtask

  // Every coefficient is written before any sample is sent, so no read ever
  // touches an entry that was never loaded.
  task automatic load_full_response();
    for (int t = 0; t < NUM_TAPS; t++) begin
      if (t == 0)      load_coef(6'(t), 16'sh7fff);
      else if (t == 1) load_coef(6'(t), 16'sh8000);
      else             load_coef(6'(t), 16'($urandom));
    end
  endtask

  // A unit pulse at full scale traces out the response; two negative samples follow.
  task automatic test_impulse_response();
    set_registers(7'd64, 5'd15);
    send_sample(16'sh7fff, 1'b1);
    repeat (4) send_sample(16'sh0000, 1'b0);
    send_sample(16'sh8000, 1'b0);
    send_sample(-16'sd1, 1'b0);
  endtask

  // Three coefficients of -1.0 with no shift: two full-scale negative
  // samples already overflow upwards, three positive ones overflow downwards.
  task automatic test_saturation();
    set_registers(7'd3, 5'd0);
    for (int t = 0; t < 3; t++) load_coef(6'(t), 16'sh8000);
    send_sample(16'sh8000, 1'b1);
    send_sample(16'sh8000, 1'b0);
    send_sample(16'sh8000, 1'b0);
    send_sample(16'sh7fff, 1'b1);
    send_sample(16'sh7fff, 1'b0);
    send_sample(16'sh7fff, 1'b0);
  endtask

  // A tap count of zero acts as one; a count of 127, above the store size, acts as 64.
  task automatic test_tap_count_limits();
    set_registers(7'd0, 5'd31);
    send_sample(16'sh8000, 1'b0);
    send_sample(16'sh7fff, 1'b0);
    set_registers(7'd127, 5'd0);
    send_sample(16'sh8000, 1'b0);
    send_sample(16'sh7fff, 1'b0);
  endtask

  // A restart in the middle of a stream must hide all earlier samples.
  task automatic test_trace_restart();
    set_registers(7'd8, 5'd15);
    send_sample(16'sd1000, 1'b1);
    send_sample(16'sd2000, 1'b0);
    send_sample(16'sd3000, 1'b1);
    send_sample(-16'sd4000, 1'b0);
  endtask

  // Random stream: mostly traces of random length, with coefficient reloads
  // mixed in and the odd premature restart.
  function automatic rcfir_pkg::item_t random_item();
    rcfir_pkg::item_t it;
    it = rcfir_pkg::item_t'(ITEM_W'({$urandom, $urandom}));
    if ($urandom_range(9) == 0) begin
      it.cmd = rcfir_pkg::CMD_LOAD;
      case ($urandom_range(7))
        0: it.coef_value = 16'sh7fff;
        1: it.coef_value = 16'sh8000;
        default: ;
      endcase
    end else begin
      it.cmd = rcfir_pkg::CMD_SAMPLE;
      if (trace_left == 0) begin
        it.first_of_trace = 1'b1;
        trace_left = $urandom_range(1, 120);
      end else
        it.first_of_trace = ($urandom_range(49) == 0);
      trace_left--;
      case ($urandom_range(7))
        0: it.sample_value = 16'sh7fff;
        1: it.sample_value = 16'sh8000;
        default: ;
      endcase
    end
    return it;
  endfunction

  // One random phase. The first few phases pin the register extremes; later
  // ones mostly use short responses so that the run stays quick.
  task automatic run_random_phase(int phase);
    logic [6:0] taps;
    logic [4:0] shift;
    case (phase)
      0: begin taps = 7'd1;   shift = 5'd0;  end
      1: begin taps = 7'd64;  shift = 5'd31; end
      2: begin taps = 7'd127; shift = 5'd15; end
      3: begin taps = 7'd0;   shift = 5'd0;  end
      default: begin
        taps  = ($urandom_range(3) == 0) ? 7'($urandom_range(17, 127))
                                         : 7'($urandom_range(1, 16));
        shift = 5'($urandom);
      end
    endcase
    set_registers(taps, shift);
    case (phase % 4)
      0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
      1: begin send_idle_pct = 61; recv_stall_pct = 0;  end
      2: begin send_idle_pct = 0;  recv_stall_pct = 61; end
      default: begin send_idle_pct = 32; recv_stall_pct = 32; end
    endcase
    repeat (ITEMS_PER_PHASE) begin
      // Now and then the sender waits for the block to empty completely.
      if ($urandom_range(59) == 0) hold_until_drained(0);
      send_item(random_item());
    end
    send_idle_pct  = 0;
    recv_stall_pct = 0;
  endtask

  initial begin
    foreach (trace_hist[i]) trace_hist[i] = '0;
    foreach (resp_coef[i])  resp_coef[i]  = '0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    load_full_response();
    test_impulse_response();
    test_saturation();
    test_tap_count_limits();
    test_trace_restart();
    for (int p = 0; p < RANDOM_PHASES; p++) run_random_phase(p);

    hold_until_drained(SETTLE_CYCLES);
    if (pending_results.size() != 0) begin
      $display("%t: %0d results never arrived", $time, pending_results.size());
      mismatches++;
    end

    $display("Sent %0d items: %0d samples and %0d coefficient loads;",
             items_sent, samples_sent, loads_sent);
    $display("%0d results checked, %0d clipped; %0d register writes over %0d %s %0d cycles.",
             results_checked, clipped_seen, cfg_writes, RANDOM_PHASES,
             "random phases with varied idling, in", cycle_count);
    if (mismatches == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end

endmodule

[sim.f]
src/rcfir_pkg.sv
src/rcfir_ram.sv
src/rcfir_mac.sv
src/rcfir_post.sv
src/response_convolution_fir.sv
test/response_convolution_fir_test.sv
